FILE: rtl/snfcs_pkg.sv
`default_nettype none
package snfcs_pkg;

   localparam int PAGE_BYTES_DEFAULT   = 256;
   localparam int SECTOR_COUNT_DEFAULT = 16;
   localparam int QUEUE_DEPTH          = 2;
   localparam int PC_W                 = 6;

   localparam logic [3:0] REQ_READ_BEGIN   = 4'd0;
   localparam logic [3:0] REQ_READ_NEXT    = 4'd1;
   localparam logic [3:0] REQ_WRITE_BEGIN  = 4'd2;
   localparam logic [3:0] REQ_WRITE_BYTE   = 4'd3;
   localparam logic [3:0] REQ_BULK_ERASE   = 4'd4;
   localparam logic [3:0] REQ_SECTOR_ERASE = 4'd5;
   localparam logic [3:0] REQ_SIGNATURE    = 4'd6;
   localparam logic [3:0] REQ_BUSY_QUERY   = 4'd7;
   localparam logic [3:0] REQ_SPI_BYTE_IN  = 4'd8;

   localparam logic [2:0] ACT_CS_LOW  = 3'd0;
   localparam logic [2:0] ACT_CS_HIGH = 3'd1;
   localparam logic [2:0] ACT_SEND    = 3'd2;
   localparam logic [2:0] ACT_RECV    = 3'd3;
   localparam logic [2:0] ACT_DELIVER = 3'd4;
   localparam logic [2:0] ACT_DONE    = 3'd5;
   localparam logic [2:0] ACT_REJECT  = 3'd6;

   localparam logic [7:0] CMD_READ_STATUS  = 8'h05;
   localparam logic [7:0] CMD_READ         = 8'h03;
   localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
   localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_BULK_ERASE   = 8'hc7;
   localparam logic [7:0] CMD_SECTOR_ERASE = 8'hd8;
   localparam logic [7:0] CMD_SIGNATURE    = 8'hab;
   localparam logic [7:0] CMD_DUMMY        = 8'h00;

   // Start and stop points of sequences in the action program.
   localparam logic [PC_W-1:0] PC_REOPEN        = 6'd0;
   localparam logic [PC_W-1:0] PC_WRITE_BEGIN   = 6'd1;
   localparam logic [PC_W-1:0] PC_WRITE_OPEN_END = 6'd8;
   localparam logic [PC_W-1:0] PC_POLL_AGAIN    = 6'd9;
   localparam logic [PC_W-1:0] PC_POLL          = 6'd10;
   localparam logic [PC_W-1:0] PC_POLL_END      = 6'd12;
   localparam logic [PC_W-1:0] PC_READ_BEGIN    = 6'd13;
   localparam logic [PC_W-1:0] PC_READ_OPEN_END = 6'd17;
   localparam logic [PC_W-1:0] PC_READ_CLOSE    = 6'd18;
   localparam logic [PC_W-1:0] PC_DONE          = 6'd19;
   localparam logic [PC_W-1:0] PC_BULK          = 6'd20;
   localparam logic [PC_W-1:0] PC_BULK_END      = 6'd28;
   localparam logic [PC_W-1:0] PC_SECTOR        = 6'd29;
   localparam logic [PC_W-1:0] PC_SECTOR_END    = 6'd40;
   localparam logic [PC_W-1:0] PC_SEND          = 6'd41;
   localparam logic [PC_W-1:0] PC_SEND_CLOSE_END = 6'd45;
   localparam logic [PC_W-1:0] PC_SIG           = 6'd46;
   localparam logic [PC_W-1:0] PC_SIG_END       = 6'd51;
   localparam logic [PC_W-1:0] PC_DELIVER       = 6'd52;
   localparam logic [PC_W-1:0] PC_DELIVER_CLOSE = 6'd53;
   localparam logic [PC_W-1:0] PC_STATUS        = 6'd54;
   localparam logic [PC_W-1:0] PC_STATUS_END    = 6'd55;
   localparam logic [PC_W-1:0] PC_SIG_DONE      = 6'd56;
   localparam logic [PC_W-1:0] PC_SIG_DONE_END  = 6'd57;
   localparam logic [PC_W-1:0] PC_REJECT        = 6'd58;

   typedef enum logic [2:0] {
      VS_ZERO,
      VS_CONST,
      VS_ADDR_HI,
      VS_ADDR_MID,
      VS_ADDR_LO,
      VS_BYTE,
      VS_BIT0
   } val_sel_type;

   typedef struct packed {
      logic [2:0]  act;
      val_sel_type sel;
      logic [7:0]  konst;
   } rom_entry_type;

   typedef struct packed {
      logic [PC_W-1:0] start_pc;
      logic [PC_W-1:0] stop_pc;
      logic [23:0]     addr;
      logic [7:0]      data;
   } desc_type;

   function automatic rom_entry_type ent(input logic [2:0] act, input val_sel_type sel,
                                         input logic [7:0] konst);
      rom_entry_type e;
      e.act   = act;
      e.sel   = sel;
      e.konst = konst;
      return e;
   endfunction

   function automatic rom_entry_type csl();
      return ent(ACT_CS_LOW, VS_ZERO, 8'h00);
   endfunction

   function automatic rom_entry_type csh();
      return ent(ACT_CS_HIGH, VS_ZERO, 8'h00);
   endfunction

   function automatic rom_entry_type snd(input logic [7:0] b);
      return ent(ACT_SEND, VS_CONST, b);
   endfunction

   function automatic rom_entry_type rcv();
      return ent(ACT_RECV, VS_ZERO, 8'h00);
   endfunction

   function automatic rom_entry_type rom_read(input logic [PC_W-1:0] pc);
      rom_entry_type e;
      unique case (pc)
         6'd0:  e = csh();
         6'd1:  e = csl();
         6'd2:  e = snd(CMD_WRITE_ENABLE);
         6'd3:  e = csh();
         6'd4:  e = csl();
         6'd5:  e = snd(CMD_PAGE_PROGRAM);
         6'd6:  e = ent(ACT_SEND, VS_ADDR_HI, 8'h00);
         6'd7:  e = ent(ACT_SEND, VS_ADDR_MID, 8'h00);
         6'd8:  e = ent(ACT_SEND, VS_ADDR_LO, 8'h00);
         6'd9:  e = csh();
         6'd10: e = csl();
         6'd11: e = snd(CMD_READ_STATUS);
         6'd12: e = rcv();
         6'd13: e = csl();
         6'd14: e = snd(CMD_READ);
         6'd15: e = ent(ACT_SEND, VS_ADDR_HI, 8'h00);
         6'd16: e = ent(ACT_SEND, VS_ADDR_MID, 8'h00);
         6'd17: e = ent(ACT_SEND, VS_ADDR_LO, 8'h00);
         6'd18: e = csh();
         6'd19: e = ent(ACT_DONE, VS_ZERO, 8'h00);
         6'd20: e = csl();
         6'd21: e = snd(CMD_WRITE_ENABLE);
         6'd22: e = csh();
         6'd23: e = csl();
         6'd24: e = snd(CMD_BULK_ERASE);
         6'd25: e = csh();
         6'd26: e = csl();
         6'd27: e = snd(CMD_READ_STATUS);
         6'd28: e = rcv();
         6'd29: e = csl();
         6'd30: e = snd(CMD_WRITE_ENABLE);
         6'd31: e = csh();
         6'd32: e = csl();
         6'd33: e = snd(CMD_SECTOR_ERASE);
         6'd34: e = ent(ACT_SEND, VS_BYTE, 8'h00);
         6'd35: e = snd(CMD_DUMMY);
         6'd36: e = snd(CMD_DUMMY);
         6'd37: e = csh();
         6'd38: e = csl();
         6'd39: e = snd(CMD_READ_STATUS);
         6'd40: e = rcv();
         6'd41: e = ent(ACT_SEND, VS_BYTE, 8'h00);
         6'd42: e = csh();
         6'd43: e = csl();
         6'd44: e = snd(CMD_READ_STATUS);
         6'd45: e = rcv();
         6'd46: e = csl();
         6'd47: e = snd(CMD_SIGNATURE);
         6'd48: e = snd(CMD_DUMMY);
         6'd49: e = snd(CMD_DUMMY);
         6'd50: e = snd(CMD_DUMMY);
         6'd51: e = rcv();
         6'd52: e = ent(ACT_DELIVER, VS_BYTE, 8'h00);
         6'd53: e = csh();
         6'd54: e = csh();
         6'd55: e = ent(ACT_DELIVER, VS_BIT0, 8'h00);
         6'd56: e = csh();
         6'd57: e = ent(ACT_DELIVER, VS_BYTE, 8'h00);
         default: e = ent(ACT_REJECT, VS_ZERO, 8'h00);
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/snfcs_if.sv
`default_nettype none
interface snfcs_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [23:0] flash_address;
   logic [7:0]  data_byte;
   logic        end_of_run;

   modport source (output valid, output req_type, output flash_address, output data_byte,
                   output end_of_run, input ready);
   modport sink (input valid, input req_type, input flash_address, input data_byte,
                 input end_of_run, output ready);
endinterface

interface snfcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] value;
   logic       last;

   modport source (output valid, output action, output value, output last, input ready);
   modport sink (input valid, input action, input value, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/snfcs_front.sv
`default_nettype none
module snfcs_front
   import snfcs_pkg::*;
#(
   parameter int PAGE_BYTES   = PAGE_BYTES_DEFAULT,
   parameter int SECTOR_COUNT = SECTOR_COUNT_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   snfcs_req_if.sink     req_chan,
   output desc_type      push_desc,
   output logic          push_valid,
   input  wire logic     push_ready
);

   localparam int PAGE_BITS = $clog2(PAGE_BYTES);

   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_READ_OPEN  = 8'b0000_0010,
      PH_READ_WAIT  = 8'b0000_0100,
      PH_WRITE_OPEN = 8'b0000_1000,
      PH_POLL_PAGE  = 8'b0001_0000,
      PH_POLL_FINAL = 8'b0010_0000,
      PH_BUSY_WAIT  = 8'b0100_0000,
      PH_SIG_WAIT   = 8'b1000_0000
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [23:0]     track_ff, track_in;
   logic            pend_ff, pend_in;
   logic [PC_W-1:0] start_pc, stop_pc;
   logic [23:0]     addr_inc;
   logic            boundary;
   logic            sector_bad;
   logic            req_fire;

   assign req_fire       = req_chan.valid && push_ready;
   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign addr_inc       = track_ff + 24'd1;
   assign boundary       = (addr_inc[PAGE_BITS-1:0] == '0);
   assign sector_bad     = ({1'b0, req_chan.data_byte} >= 9'(SECTOR_COUNT));

   always_comb begin
      phase_in = phase_ff;
      track_in = track_ff;
      pend_in  = pend_ff;
      start_pc = PC_REJECT;
      stop_pc  = PC_REJECT;
      unique case (phase_ff) inside
         PH_IDLE: begin
            unique case (req_chan.req_type)
               REQ_READ_BEGIN: begin
                  start_pc = PC_READ_BEGIN;
                  if (req_chan.end_of_run) begin
                     stop_pc = PC_READ_CLOSE;
                  end else begin
                     stop_pc  = PC_READ_OPEN_END;
                     phase_in = PH_READ_OPEN;
                  end
               end
               REQ_WRITE_BEGIN: begin
                  track_in = req_chan.flash_address;
                  start_pc = PC_WRITE_BEGIN;
                  if (req_chan.end_of_run) begin
                     stop_pc  = PC_POLL_END;
                     phase_in = PH_POLL_FINAL;
                  end else begin
                     stop_pc  = PC_WRITE_OPEN_END;
                     phase_in = PH_WRITE_OPEN;
                  end
               end
               REQ_BULK_ERASE: begin
                  start_pc = PC_BULK;
                  stop_pc  = PC_BULK_END;
                  phase_in = PH_POLL_FINAL;
               end
               REQ_SECTOR_ERASE: begin
                  if (!sector_bad) begin
                     start_pc = PC_SECTOR;
                     stop_pc  = PC_SECTOR_END;
                     phase_in = PH_POLL_FINAL;
                  end
               end
               REQ_SIGNATURE: begin
                  start_pc = PC_SIG;
                  stop_pc  = PC_SIG_END;
                  phase_in = PH_SIG_WAIT;
               end
               REQ_BUSY_QUERY: begin
                  start_pc = PC_POLL;
                  stop_pc  = PC_POLL_END;
                  phase_in = PH_BUSY_WAIT;
               end
               default: begin
               end
            endcase
         end
         PH_READ_OPEN: begin
            if (req_chan.req_type == REQ_READ_NEXT) begin
               start_pc = PC_POLL_END;
               stop_pc  = PC_POLL_END;
               pend_in  = req_chan.end_of_run;
               phase_in = PH_READ_WAIT;
            end
         end
         PH_READ_WAIT: begin
            if (req_chan.req_type == REQ_SPI_BYTE_IN) begin
               start_pc = PC_DELIVER;
               pend_in  = 1'b0;
               if (pend_ff) begin
                  stop_pc  = PC_DELIVER_CLOSE;
                  phase_in = PH_IDLE;
               end else begin
                  stop_pc  = PC_DELIVER;
                  phase_in = PH_READ_OPEN;
               end
            end
         end
         PH_WRITE_OPEN: begin
            if (req_chan.req_type == REQ_WRITE_BYTE) begin
               track_in = addr_inc;
               start_pc = PC_SEND;
               if (boundary) begin
                  stop_pc  = PC_SEND_CLOSE_END;
                  pend_in  = req_chan.end_of_run;
                  phase_in = PH_POLL_PAGE;
               end else if (req_chan.end_of_run) begin
                  stop_pc  = PC_SEND_CLOSE_END;
                  phase_in = PH_POLL_FINAL;
               end else begin
                  stop_pc = PC_SEND;
               end
            end
         end
         PH_POLL_PAGE, PH_POLL_FINAL: begin
            if (req_chan.req_type == REQ_SPI_BYTE_IN) begin
               if (req_chan.data_byte[0]) begin
                  start_pc = PC_POLL_AGAIN;
                  stop_pc  = PC_POLL_END;
               end else if (phase_ff == PH_POLL_FINAL) begin
                  start_pc = PC_READ_CLOSE;
                  stop_pc  = PC_DONE;
                  phase_in = PH_IDLE;
               end else begin
                  start_pc = PC_REOPEN;
                  pend_in  = 1'b0;
                  if (pend_ff) begin
                     stop_pc  = PC_POLL_END;
                     phase_in = PH_POLL_FINAL;
                  end else begin
                     stop_pc  = PC_WRITE_OPEN_END;
                     phase_in = PH_WRITE_OPEN;
                  end
               end
            end
         end
         PH_BUSY_WAIT: begin
            if (req_chan.req_type == REQ_SPI_BYTE_IN) begin
               start_pc = PC_STATUS;
               stop_pc  = PC_STATUS_END;
               phase_in = PH_IDLE;
            end
         end
         PH_SIG_WAIT: begin
            if (req_chan.req_type == REQ_SPI_BYTE_IN) begin
               start_pc = PC_SIG_DONE;
               stop_pc  = PC_SIG_DONE_END;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      push_desc.start_pc = start_pc;
      push_desc.stop_pc  = stop_pc;
      push_desc.data     = req_chan.data_byte;
      if ((req_chan.req_type == REQ_READ_BEGIN) || (req_chan.req_type == REQ_WRITE_BEGIN)) begin
         push_desc.addr = req_chan.flash_address;
      end else begin
         push_desc.addr = track_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         track_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         track_ff <= track_in;
         pend_ff  <= pend_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/snfcs_queue.sv
`default_nettype none
module snfcs_queue
   import snfcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type push_desc,
   input  wire logic     push_valid,
   output logic          push_ready,
   output desc_type      pop_desc,
   output logic          pop_valid,
   input  wire logic     pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/snfcs_back.sv
`default_nettype none
module snfcs_back
   import snfcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type pop_desc,
   input  wire logic     pop_valid,
   output logic          pop_ready,
   snfcs_rsp_if.source   rsp_chan
);

   logic            active_ff;
   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] stop_ff;
   logic [23:0]     addr_ff;
   logic [7:0]      data_ff;
   rom_entry_type   entry;
   logic            at_stop;
   logic            rsp_fire;
   logic            load;

   assign entry     = rom_read(pc_ff);
   assign at_stop   = (pc_ff == stop_ff);
   assign rsp_fire  = active_ff && rsp_chan.ready;
   assign load      = !active_ff || (rsp_fire && at_stop);
   assign pop_ready = load;

   assign rsp_chan.valid  = active_ff;
   assign rsp_chan.action = entry.act;
   assign rsp_chan.last   = at_stop;

   always_comb begin
      unique case (entry.sel)
         VS_CONST:    rsp_chan.value = entry.konst;
         VS_ADDR_HI:  rsp_chan.value = addr_ff[23:16];
         VS_ADDR_MID: rsp_chan.value = addr_ff[15:8];
         VS_ADDR_LO:  rsp_chan.value = addr_ff[7:0];
         VS_BYTE:     rsp_chan.value = data_ff;
         VS_BIT0:     rsp_chan.value = {7'd0, data_ff[0]};
         default:     rsp_chan.value = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pc_ff     <= PC_REJECT;
         stop_ff   <= PC_REJECT;
      end else if (load) begin
         active_ff <= pop_valid;
         if (pop_valid) begin
            pc_ff   <= pop_desc.start_pc;
            stop_ff <= pop_desc.stop_pc;
         end
      end else if (rsp_fire) begin
         pc_ff <= pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         addr_ff <= pop_desc.addr;
         data_ff <= pop_desc.data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/spi_nor_flash_command_sequencer.sv
`default_nettype none
// A taken request is written into a queue slot, then the back end loads its start pc.
// Throughput: one action per cycle unless the receiver stalls; requests have 1 to 13 actions.
// A two-entry queue lets requests enter while earlier actions are still being delivered.
// PAGE_BYTES must be a power of two; the page boundary is found by masking the address.
// Reset is synchronous and active high: phase returns to idle, address and queue clear.
module spi_nor_flash_command_sequencer
   import snfcs_pkg::*;
#(
   parameter int PAGE_BYTES   = PAGE_BYTES_DEFAULT,
   parameter int SECTOR_COUNT = SECTOR_COUNT_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   snfcs_req_if.sink   req_chan,
   snfcs_rsp_if.source rsp_chan
);

   desc_type push_desc, pop_desc;
   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;

   snfcs_front #(
      .PAGE_BYTES   (PAGE_BYTES),
      .SECTOR_COUNT (SECTOR_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_desc  (push_desc),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   snfcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_desc  (push_desc),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_desc   (pop_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   snfcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_desc  (pop_desc),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: sim/spi_nor_flash_command_sequencer_test.sv
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_test;
   import snfcs_pkg::*;

   typedef enum logic [3:0] {
      FP_IDLE,
      FP_READ_OPEN,
      FP_READ_WAIT,
      FP_WRITE_OPEN,
      FP_POLL_PAGE,
      FP_POLL_FINAL,
      FP_BUSY_WAIT,
      FP_SIG_WAIT
   } flash_phase_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [23:0] address;
      logic [7:0]  data;
      logic        eor;
   } host_request_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] value;
      logic       last;
   } wire_action_type;

   typedef struct packed {
      host_request_type req;
      logic             typed;
      logic [2:0]       typed_action;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset;

   snfcs_req_if req_chan ();
   snfcs_rsp_if rsp_chan ();

   spi_nor_flash_command_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   flash_phase_type  model_phase;
   logic [23:0]      model_address;
   logic             model_end_pending;
   wire_action_type  step_actions[$];
   wire_action_type  expected_actions[$];
   int               mismatch_count;
   int               send_idle_pct;
   int               recv_idle_pct;
   logic             row_typed;
   logic [2:0]       row_typed_action;
   stimulus_row_type directed_rows [0:26];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void emit(input logic [2:0] act, input logic [7:0] val);
      wire_action_type a;
      a.action = act;
      a.value  = val;
      a.last   = 1'b0;
      step_actions.push_back(a);
   endfunction

   function automatic void emit_address(input logic [23:0] addr);
      emit(ACT_SEND, addr[23:16]);
      emit(ACT_SEND, addr[15:8]);
      emit(ACT_SEND, addr[7:0]);
   endfunction

   function automatic void emit_write_enable();
      emit(ACT_CS_LOW, 8'h00);
      emit(ACT_SEND, CMD_WRITE_ENABLE);
      emit(ACT_CS_HIGH, 8'h00);
   endfunction

   function automatic void emit_status_poll();
      emit(ACT_CS_LOW, 8'h00);
      emit(ACT_SEND, CMD_READ_STATUS);
      emit(ACT_RECV, 8'h00);
   endfunction

   function automatic void emit_program_open(input logic [23:0] addr);
      emit_write_enable();
      emit(ACT_CS_LOW, 8'h00);
      emit(ACT_SEND, CMD_PAGE_PROGRAM);
      emit_address(addr);
   endfunction

   task automatic expand_request(input host_request_type r);
      logic            ok;
      wire_action_type tail;
      ok = 1'b1;
      step_actions.delete();
      case (model_phase) inside
         FP_IDLE: begin
            case (r.kind)
               REQ_READ_BEGIN: begin
                  emit(ACT_CS_LOW, 8'h00);
                  emit(ACT_SEND, CMD_READ);
                  emit_address(r.address);
                  if (r.eor) begin
                     emit(ACT_CS_HIGH, 8'h00);
                  end else begin
                     model_phase = FP_READ_OPEN;
                  end
               end
               REQ_WRITE_BEGIN: begin
                  model_address = r.address;
                  emit_program_open(r.address);
                  if (r.eor) begin
                     emit(ACT_CS_HIGH, 8'h00);
                     emit_status_poll();
                     model_phase = FP_POLL_FINAL;
                  end else begin
                     model_phase = FP_WRITE_OPEN;
                  end
               end
               REQ_BULK_ERASE: begin
                  emit_write_enable();
                  emit(ACT_CS_LOW, 8'h00);
                  emit(ACT_SEND, CMD_BULK_ERASE);
                  emit(ACT_CS_HIGH, 8'h00);
                  emit_status_poll();
                  model_phase = FP_POLL_FINAL;
               end
               REQ_SECTOR_ERASE: begin
                  if (r.data >= SECTOR_COUNT_DEFAULT) begin
                     ok = 1'b0;
                  end else begin
                     emit_write_enable();
                     emit(ACT_CS_LOW, 8'h00);
                     emit(ACT_SEND, CMD_SECTOR_ERASE);
                     emit(ACT_SEND, r.data);
                     emit(ACT_SEND, CMD_DUMMY);
                     emit(ACT_SEND, CMD_DUMMY);
                     emit(ACT_CS_HIGH, 8'h00);
                     emit_status_poll();
                     model_phase = FP_POLL_FINAL;
                  end
               end
               REQ_SIGNATURE: begin
                  emit(ACT_CS_LOW, 8'h00);
                  emit(ACT_SEND, CMD_SIGNATURE);
                  emit(ACT_SEND, CMD_DUMMY);
                  emit(ACT_SEND, CMD_DUMMY);
                  emit(ACT_SEND, CMD_DUMMY);
                  emit(ACT_RECV, 8'h00);
                  model_phase = FP_SIG_WAIT;
               end
               REQ_BUSY_QUERY: begin
                  emit_status_poll();
                  model_phase = FP_BUSY_WAIT;
               end
               default: ok = 1'b0;
            endcase
         end
         FP_READ_OPEN: begin
            if (r.kind == REQ_READ_NEXT) begin
               emit(ACT_RECV, 8'h00);
               model_end_pending = r.eor;
               model_phase = FP_READ_WAIT;
            end else begin
               ok = 1'b0;
            end
         end
         FP_READ_WAIT: begin
            if (r.kind == REQ_SPI_BYTE_IN) begin
               emit(ACT_DELIVER, r.data);
               if (model_end_pending) begin
                  emit(ACT_CS_HIGH, 8'h00);
                  model_phase = FP_IDLE;
               end else begin
                  model_phase = FP_READ_OPEN;
               end
               model_end_pending = 1'b0;
            end else begin
               ok = 1'b0;
            end
         end
         FP_WRITE_OPEN: begin
            if (r.kind == REQ_WRITE_BYTE) begin
               emit(ACT_SEND, r.data);
               model_address = model_address + 24'd1;
               if ((model_address % PAGE_BYTES_DEFAULT) == 0) begin
                  emit(ACT_CS_HIGH, 8'h00);
                  emit_status_poll();
                  model_end_pending = r.eor;
                  model_phase = FP_POLL_PAGE;
               end else if (r.eor) begin
                  emit(ACT_CS_HIGH, 8'h00);
                  emit_status_poll();
                  model_phase = FP_POLL_FINAL;
               end
            end else begin
               ok = 1'b0;
            end
         end
         FP_POLL_PAGE, FP_POLL_FINAL: begin
            if (r.kind == REQ_SPI_BYTE_IN) begin
               emit(ACT_CS_HIGH, 8'h00);
               if (r.data[0]) begin
                  emit_status_poll();
               end else if (model_phase == FP_POLL_FINAL) begin
                  emit(ACT_DONE, 8'h00);
                  model_phase = FP_IDLE;
               end else begin
                  emit_program_open(model_address);
                  if (model_end_pending) begin
                     emit(ACT_CS_HIGH, 8'h00);
                     emit_status_poll();
                     model_phase = FP_POLL_FINAL;
                  end else begin
                     model_phase = FP_WRITE_OPEN;
                  end
                  model_end_pending = 1'b0;
               end
            end else begin
               ok = 1'b0;
            end
         end
         FP_BUSY_WAIT, FP_SIG_WAIT: begin
            if (r.kind == REQ_SPI_BYTE_IN) begin
               emit(ACT_CS_HIGH, 8'h00);
               if (model_phase == FP_BUSY_WAIT) begin
                  emit(ACT_DELIVER, {7'd0, r.data[0]});
               end else begin
                  emit(ACT_DELIVER, r.data);
               end
               model_phase = FP_IDLE;
            end else begin
               ok = 1'b0;
            end
         end
         default: begin
            model_phase = FP_IDLE;
            ok = 1'b0;
         end
      endcase
      if (!ok) begin
         step_actions.delete();
         emit(ACT_REJECT, 8'h00);
      end
      tail = step_actions.pop_back();
      tail.last = 1'b1;
      step_actions.push_back(tail);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic stimulus_row_type stimulus_row(input logic [3:0] kind,
                                                     input logic [23:0] addr,
                                                     input logic [7:0] data, input logic eor,
                                                     input logic typed, input logic [2:0] act);
      stimulus_row_type s;
      s.req.kind     = kind;
      s.req.address  = addr;
      s.req.data     = data;
      s.req.eor      = eor;
      s.typed        = typed;
      s.typed_action = act;
      return s;
   endfunction

   // Mostly well-formed for the current phase; the rest is unconstrained noise.
   function automatic host_request_type random_request();
      host_request_type r;
      r.kind    = 4'($urandom_range(15));
      r.address = 24'($urandom);
      r.data    = 8'($urandom);
      r.eor     = 1'($urandom_range(1));
      if ($urandom_range(99) < 12) begin
         return r;
      end
      r.eor = ($urandom_range(9) == 0);
      case (model_phase) inside
         FP_IDLE: begin
            case ($urandom_range(5))
               0: r.kind = REQ_READ_BEGIN;
               1: begin
                  r.kind = REQ_WRITE_BEGIN;
                  if ($urandom_range(3) != 0) begin
                     r.address[7:4] = 4'hf;
                  end
               end
               2: r.kind = REQ_BULK_ERASE;
               3: begin
                  r.kind = REQ_SECTOR_ERASE;
                  if ($urandom_range(7) != 0) begin
                     r.data = 8'($urandom_range(SECTOR_COUNT_DEFAULT - 1));
                  end
               end
               4: r.kind = REQ_SIGNATURE;
               default: r.kind = REQ_BUSY_QUERY;
            endcase
         end
         FP_READ_OPEN: begin
            r.kind = REQ_READ_NEXT;
            r.eor  = ($urandom_range(3) == 0);
         end
         FP_WRITE_OPEN: begin
            r.kind = REQ_WRITE_BYTE;
            r.eor  = ($urandom_range(11) == 0);
         end
         FP_POLL_PAGE, FP_POLL_FINAL: begin
            r.kind    = REQ_SPI_BYTE_IN;
            r.data[0] = ($urandom_range(9) < 3);
         end
         default: r.kind = REQ_SPI_BYTE_IN;
      endcase
      return r;
   endfunction

   task automatic drive_request(input host_request_type r, input logic typed,
                                input logic [2:0] typed_act);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.req_type      = r.kind;
      req_chan.flash_address = r.address;
      req_chan.data_byte     = r.data;
      req_chan.end_of_run    = r.eor;
      row_typed              = typed;
      row_typed_action       = typed_act;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drive_random(input int count);
      for (int i = 0; i < count; i++) begin
         drive_request(random_request(), 1'b0, ACT_REJECT);
      end
   endtask

   task automatic wait_drained();
      while (expected_actions.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      host_request_type r;
      wire_action_type  want;
      wire_action_type  typed_result;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            r.kind    = req_chan.req_type;
            r.address = req_chan.flash_address;
            r.data    = req_chan.data_byte;
            r.eor     = req_chan.end_of_run;
            expand_request(r);
            if (row_typed) begin
               typed_result.action = row_typed_action;
               typed_result.value  = 8'h00;
               typed_result.last   = 1'b1;
               step_actions.delete();
               step_actions.push_back(typed_result);
            end
            foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_actions.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction action %0d value %02h last %0b",
                                         rsp_chan.action, rsp_chan.value, rsp_chan.last));
            end else begin
               want = expected_actions.pop_front();
               if (rsp_chan.action !== want.action) begin
                  report_mismatch($sformatf("action got %0d want %0d",
                                            rsp_chan.action, want.action));
               end
               if (rsp_chan.value !== want.value) begin
                  report_mismatch($sformatf("value got %02h want %02h (action %0d)",
                                            rsp_chan.value, want.value, want.action));
               end
               if (rsp_chan.last !== want.last) begin
                  report_mismatch($sformatf("last got %0b want %0b (action %0d)",
                                            rsp_chan.last, want.last, want.action));
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = REQ_READ_BEGIN;
      req_chan.flash_address = 24'h000000;
      req_chan.data_byte     = 8'h00;
      req_chan.end_of_run    = 1'b0;
      rsp_chan.ready         = 1'b0;
      row_typed              = 1'b0;
      row_typed_action       = ACT_REJECT;
      model_phase            = FP_IDLE;
      model_address          = 24'h000000;
      model_end_pending      = 1'b0;
      mismatch_count         = 0;
      send_idle_pct          = 20;
      recv_idle_pct          = 74;
      directed_rows = '{
         stimulus_row(REQ_READ_NEXT,    24'h000000, 8'h00, 1'b0, 1'b1, ACT_REJECT),
         stimulus_row(4'd15,            24'hffffff, 8'hff, 1'b1, 1'b1, ACT_REJECT),
         stimulus_row(REQ_SECTOR_ERASE, 24'h000000, 8'h10, 1'b0, 1'b1, ACT_REJECT),
         stimulus_row(REQ_READ_BEGIN,   24'hffffff, 8'h00, 1'b1, 1'b0, ACT_REJECT),
         stimulus_row(REQ_READ_BEGIN,   24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_WRITE_BYTE,   24'h000000, 8'h11, 1'b0, 1'b1, ACT_REJECT),
         stimulus_row(REQ_READ_NEXT,    24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SIGNATURE,    24'h000000, 8'h00, 1'b0, 1'b1, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'hff, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_READ_NEXT,    24'h000000, 8'h00, 1'b1, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_WRITE_BEGIN,  24'hfffffe, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_WRITE_BYTE,   24'h000000, 8'ha5, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_WRITE_BYTE,   24'h000000, 8'hff, 1'b1, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h01, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'hfe, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_WRITE_BEGIN,  24'h000100, 8'h00, 1'b1, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_BULK_ERASE,   24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SECTOR_ERASE, 24'h000000, 8'h0f, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_BUSY_QUERY,   24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'hff, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SIGNATURE,    24'h000000, 8'h00, 1'b0, 1'b0, ACT_REJECT),
         stimulus_row(REQ_SPI_BYTE_IN,  24'h000000, 8'h5a, 1'b0, 1'b0, ACT_REJECT)
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         drive_request(directed_rows[k].req, directed_rows[k].typed,
                       directed_rows[k].typed_action);
      end
      drive_random(85);

      // Hold the sender off until every outstanding transaction has drained.
      req_chan.valid = 1'b0;
      wait_drained();
      send_idle_pct = 74;
      recv_idle_pct = 20;
      drive_random(85);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      drive_random(83);

      req_chan.valid = 1'b0;
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: spi_nor_flash_command_sequencer.f
rtl/snfcs_pkg.sv
rtl/snfcs_if.sv
rtl/snfcs_front.sv
rtl/snfcs_queue.sv
rtl/snfcs_back.sv
rtl/spi_nor_flash_command_sequencer.sv
sim/spi_nor_flash_command_sequencer_test.sv
